// ===== hdl/assert_macros.svh =====
// assertion helpers used by quadrature_speed_estimator to check its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/qse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_pkg
// Widths, codes, reset values and shared types of the quadrature speed
// estimator.
// ----------------------------------------------------------------------------
package qse_pkg;

  localparam int KIND_W   = 2;
  localparam int TIME_W   = 32;
  localparam int SPEED_W  = 32;
  localparam int COUNT_W  = 9;
  localparam int WINDOW_W = 8;
  localparam int SCALE_W  = 32;
  localparam int PROD_W   = SCALE_W + WINDOW_W;

  localparam int TIME_BITS_DEFAULT = 32;

  localparam logic [KIND_W-1:0] KIND_EDGE_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd2;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCALE   = 2'd2;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET  = 8'd12;
  localparam logic [TIME_W-1:0]   TIMEOUT_RESET = 32'd100000;
  localparam logic [SCALE_W-1:0]  SCALE_RESET   = 32'd1000000;
  localparam logic [TIME_W-1:0]   CAPTURE_RESET = 32'd42;

  typedef struct packed {
    logic [WINDOW_W-1:0] window;
    logic [TIME_W-1:0]   timeout;
    logic [SCALE_W-1:0]  scale;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== hdl/qse_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_in_if
// Input channel: encoder edge events and timeout checks.
// ----------------------------------------------------------------------------
interface qse_in_if;
  logic                      valid;
  logic                      ready;
  logic [qse_pkg::KIND_W-1:0] kind;
  logic                      level_a;
  logic                      level_b;
  logic [qse_pkg::TIME_W-1:0] time_us;

  modport source (output valid, kind, level_a, level_b, time_us, input ready);
  modport sink   (input valid, kind, level_a, level_b, time_us, output ready);
endinterface

// ===== hdl/qse_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_out_if
// Output channel: speed, acceleration and pulse count after each item.
// ----------------------------------------------------------------------------
interface qse_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [qse_pkg::SPEED_W-1:0] speed_out;
  logic signed [qse_pkg::SPEED_W-1:0] accel_out;
  logic                               new_measure;
  logic signed [qse_pkg::COUNT_W-1:0] count_out;

  modport source (output valid, speed_out, accel_out, new_measure, count_out,
                  input ready);
  modport sink   (input valid, speed_out, accel_out, new_measure, count_out,
                  output ready);
endinterface

// ===== hdl/qse_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_mul
// Shift-and-add multiplier, one bit of the pulse magnitude per cycle.
// ----------------------------------------------------------------------------
module qse_mul (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [qse_pkg::SCALE_W-1:0]    multiplicand,
  input  logic [qse_pkg::WINDOW_W-1:0]   multiplier,
  output logic [qse_pkg::PROD_W-1:0]     product,
  output qse_pkg::unit_stat_t            stat
);

  localparam int CNT_W = $clog2(qse_pkg::WINDOW_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(qse_pkg::WINDOW_W - 1);

  logic                          busy;
  logic                          done;
  logic [CNT_W-1:0]              cnt;
  logic [qse_pkg::PROD_W-1:0]    acc;
  logic [qse_pkg::WINDOW_W-1:0]  mag_sr;
  logic [qse_pkg::SCALE_W-1:0]   mcand;
  logic [qse_pkg::PROD_W-1:0]    acc_next;

  // msb first: double and add
  always_comb begin
    acc_next = {acc[qse_pkg::PROD_W-2:0], 1'b0};
    if (mag_sr[qse_pkg::WINDOW_W-1]) begin
      acc_next = acc_next + qse_pkg::PROD_W'(mcand);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mag_sr <= multiplier;
      mcand  <= multiplicand;
    end else if (busy) begin
      acc    <= acc_next;
      mag_sr <= {mag_sr[qse_pkg::WINDOW_W-2:0], 1'b0};
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hdl/qse_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qse_div #(
  parameter int DIVISOR_W = qse_pkg::TIME_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [qse_pkg::PROD_W-1:0]   dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic [qse_pkg::PROD_W-1:0]   quotient,
  output qse_pkg::unit_stat_t          stat
);

  localparam int CNT_W = $clog2(qse_pkg::PROD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(qse_pkg::PROD_W - 1);

  logic                        busy;
  logic                        done;
  logic [CNT_W-1:0]            cnt;
  logic [qse_pkg::PROD_W-1:0]  dq;
  logic [DIVISOR_W-1:0]        rem;
  logic [DIVISOR_W-1:0]        dsr;
  logic [DIVISOR_W:0]          trial;
  logic [DIVISOR_W:0]          diff;
  logic                        ge;

  // remainder stays below the divisor, so the difference fits
  always_comb begin
    trial = {rem, dq[qse_pkg::PROD_W-1]};
    diff  = trial - {1'b0, dsr};
    ge    = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      dq  <= {dq[qse_pkg::PROD_W-2:0], ge};
    end
  end

  assign quotient  = dq;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hdl/qse_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qse_regs
// APB register bank: window, timeout and distance scale.
// ----------------------------------------------------------------------------
module qse_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qse_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [qse_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [qse_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output qse_pkg::cfg_t                    cfg
);

  logic [qse_pkg::REG_IDX_W-1:0] idx;
  logic                          wr;

  assign idx    = paddr[qse_pkg::APB_ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window  <= qse_pkg::WINDOW_RESET;
      cfg.timeout <= qse_pkg::TIMEOUT_RESET;
      cfg.scale   <= qse_pkg::SCALE_RESET;
    end else if (wr) begin
      case (idx)
        qse_pkg::REG_WINDOW:  cfg.window  <= pwdata[qse_pkg::WINDOW_W-1:0];
        qse_pkg::REG_TIMEOUT: cfg.timeout <= pwdata[qse_pkg::TIME_W-1:0];
        qse_pkg::REG_SCALE:   cfg.scale   <= pwdata[qse_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      qse_pkg::REG_WINDOW:  prdata = qse_pkg::APB_DATA_W'(cfg.window);
      qse_pkg::REG_TIMEOUT: prdata = qse_pkg::APB_DATA_W'(cfg.timeout);
      qse_pkg::REG_SCALE:   prdata = qse_pkg::APB_DATA_W'(cfg.scale);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== hdl/quadrature_speed_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_speed_estimator
// Fixed pulse-count speed measurement for one quadrature encoder.
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one item per encoder edge (kind A or B with both pin levels
//   and a microsecond timestamp) or a timeout check; out_ch returns exactly
//   one item per input item with speed, acceleration, pulse count and a flag
//   for a fresh measurement. the apb port sets window, timeout and scale; the
//   user writes it only while the block is idle, not enforced by the block.
//   one item is worked on at a time. an edge that does not close the window
//   and a timeout check pass through the eval and hold states, and the block
//   returns to idle as their result is raised; an edge that closes the window
//   also passes through the mul, div, fin and acc states, waiting on the 8-step
//   shift-add multiplier and the 40-step restoring divider.
//   results sit in an output register: the next item is accepted while a
//   result still waits, and its own result is held back until the register
//   is taken, so a stalled receiver only stops the flow after one item.
//   a synchronous reset clears the count, speed and acceleration, sets the
//   capture time to 42 and restores the register defaults; nothing is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadrature_speed_estimator #(
  parameter int TIME_BITS = qse_pkg::TIME_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qse_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [qse_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [qse_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  qse_in_if.sink                           in_ch,
  qse_out_if.source                        out_ch
);

  localparam int SPEED_W = qse_pkg::SPEED_W;
  localparam int COUNT_W = qse_pkg::COUNT_W;
  localparam int CMP_W   = (TIME_BITS > qse_pkg::TIME_W) ? TIME_BITS : qse_pkg::TIME_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_HOLD = 3'd6;

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

  qse_pkg::cfg_t       cfg;
  qse_pkg::unit_stat_t mul_stat;
  qse_pkg::unit_stat_t div_stat;

  logic [2:0]                       state;
  logic [qse_pkg::KIND_W-1:0]       kind_q;
  logic                             lvl_a;
  logic                             lvl_b;
  logic [TIME_BITS-1:0]             now_q;
  logic [TIME_BITS-1:0]             elapsed_q;
  logic [TIME_BITS-1:0]             capture_time;
  logic [TIME_BITS-1:0]             now_in;
  logic [TIME_BITS-1:0]             divisor;
  logic signed [COUNT_W-1:0]        pulse_count;
  logic signed [SPEED_W-1:0]        speed_reg;
  logic signed [SPEED_W-1:0]        accel_reg;
  logic signed [SPEED_W-1:0]        prev_speed;
  logic                             fresh;
  logic [qse_pkg::WINDOW_W-1:0]     mag_q;
  logic                             neg_q;
  logic                             mul_start;
  logic                             div_start;
  logic [qse_pkg::PROD_W-1:0]       product;
  logic [qse_pkg::PROD_W-1:0]       quotient;

  logic                             is_edge;
  logic                             up;
  logic signed [COUNT_W-1:0]        count_next;
  logic [COUNT_W-1:0]               count_abs;
  logic [qse_pkg::WINDOW_W-1:0]     mag;
  logic                             fire;
  logic                             timed_out;
  logic                             q_over;
  logic signed [SPEED_W-1:0]        speed_next;
  logic signed [SPEED_W:0]          diff;
  logic signed [SPEED_W-1:0]        accel_next;
  logic                             out_free;

  qse_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qse_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (cfg.scale),
    .multiplier   (mag_q),
    .product      (product),
    .stat         (mul_stat)
  );

  qse_div #(
    .DIVISOR_W (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign now_in   = TIME_BITS'(in_ch.time_us);
  assign divisor  = (elapsed_q == '0) ? TIME_BITS'(1) : elapsed_q;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);

  always_comb begin
    is_edge    = kind_q inside {qse_pkg::KIND_EDGE_A, qse_pkg::KIND_EDGE_B};
    up         = (kind_q == qse_pkg::KIND_EDGE_A) ? (lvl_a == lvl_b) : (lvl_a != lvl_b);
    count_next = up ? (pulse_count + COUNT_W'(1)) : (pulse_count - COUNT_W'(1));
    count_abs  = count_next[COUNT_W-1] ? COUNT_W'(-count_next) : COUNT_W'(count_next);
    mag        = count_abs[qse_pkg::WINDOW_W-1:0];
    fire       = (mag >= cfg.window);
    timed_out  = (CMP_W'(elapsed_q) > CMP_W'(cfg.timeout));
  end

  // quotient of 2^31 or more clamps to the limit of its sign; accel saturates too
  always_comb begin
    q_over = |quotient[qse_pkg::PROD_W-1:SPEED_W-1];
    if (neg_q) begin
      speed_next = q_over ? SPEED_MIN : -$signed(quotient[SPEED_W-1:0]);
    end else begin
      speed_next = q_over ? SPEED_MAX : $signed(quotient[SPEED_W-1:0]);
    end
    diff = {speed_reg[SPEED_W-1], speed_reg} - {prev_speed[SPEED_W-1], prev_speed};
    if (diff[SPEED_W] != diff[SPEED_W-1]) begin
      accel_next = diff[SPEED_W] ? SPEED_MIN : SPEED_MAX;
    end else begin
      accel_next = diff[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pulse_count  <= '0;
      capture_time <= TIME_BITS'(qse_pkg::CAPTURE_RESET);
      speed_reg    <= '0;
      accel_reg    <= '0;
      mul_start    <= 1'b0;
      div_start    <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      mul_start <= (state == ST_EVAL) && is_edge && fire;
      div_start <= (state == ST_MUL) && mul_stat.done;
      if (state == ST_HOLD && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state <= (is_edge && fire) ? ST_MUL : ST_HOLD;
          case (kind_q)
            qse_pkg::KIND_EDGE_A, qse_pkg::KIND_EDGE_B: begin
              if (!fire) begin
                pulse_count <= count_next;
              end
            end
            qse_pkg::KIND_CHECK: begin
              if (timed_out) begin
                speed_reg   <= '0;
                accel_reg   <= '0;
                pulse_count <= '0;
              end
            end
            default: ;
          endcase
        end
        ST_MUL: begin
          if (mul_stat.done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          speed_reg    <= speed_next;
          capture_time <= now_q;
          pulse_count  <= '0;
          state        <= ST_ACC;
        end
        ST_ACC: begin
          accel_reg <= accel_next;
          state     <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item payload and result payload need no reset
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_ch.valid) begin
      kind_q    <= in_ch.kind;
      lvl_a     <= in_ch.level_a;
      lvl_b     <= in_ch.level_b;
      now_q     <= now_in;
      elapsed_q <= now_in - capture_time;
      fresh     <= 1'b0;
    end
    if (state == ST_EVAL) begin
      mag_q <= mag;
      neg_q <= count_next[COUNT_W-1];
      if (is_edge && fire) begin
        fresh <= 1'b1;
      end
    end
    if (state == ST_FIN) begin
      prev_speed <= speed_reg;
    end
    if (state == ST_HOLD && out_free) begin
      out_ch.speed_out   <= speed_reg;
      out_ch.accel_out   <= accel_reg;
      out_ch.new_measure <= fresh;
      out_ch.count_out   <= pulse_count;
    end
  end

  `ASSERT_IMPL(a_out_load_from_hold, clk, rst, $rose(out_ch.valid), $past(state) == ST_HOLD,
    "result appeared outside the hold state")
  `ASSERT_IMPL(a_div_done_in_div, clk, rst, div_stat.done, state == ST_DIV,
    "divider finished while not awaited")
  `ASSERT_ALWAYS(a_units_exclusive, clk, rst, !(mul_stat.busy && div_stat.busy),
    "multiplier and divider busy together")
  `ASSERT_IMPL(a_fresh_clears_count, clk, rst, out_ch.valid && out_ch.new_measure,
    out_ch.count_out == '0, "measurement item with non-zero count")

endmodule
